/* sv/bmpd_pkg.sv */
`timescale 1ns / 1ps
// bmpd_pkg: shared types and constants of the BMP pixel stream decoder.
// No dependencies.
package bmpd_pkg;

    localparam int BYTE_W  = 8;
    localparam int ORG_W   = 10;
    localparam int SCR_W   = 13;
    localparam int ARGB_W  = 32;
    localparam int KIND_W  = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [KIND_W-1:0] KIND_PIXEL     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BAD_DEPTH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOO_LARGE = 2'd2;

    localparam logic REG_X_ORIGIN = 1'b0;
    localparam logic REG_Y_ORIGIN = 1'b1;

    typedef struct packed {
        logic [ORG_W-1:0] x_origin;
        logic [ORG_W-1:0] y_origin;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SCR_W-1:0]  screen_x;
        logic [SCR_W-1:0]  screen_y;
        logic [ARGB_W-1:0] argb;
        logic              last_pixel;
    } result_t;

    typedef struct packed {
        logic              step;
        logic [BYTE_W-1:0] file_byte;
        logic              first_byte;
    } step_t;

endpackage

/* sv/bmpd_cfg.sv */
`timescale 1ns / 1ps
// bmpd_cfg: APB register file holding the screen origin.
// Depends on bmpd_pkg.
module bmpd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpd_pkg::APB_AW-1:0]   paddr,
    input  logic [bmpd_pkg::APB_DW-1:0]   pwdata,
    output logic [bmpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output bmpd_pkg::cfg_t                cfg
);
    import bmpd_pkg::*;

    logic [ORG_W-1:0] x_origin_reg;
    logic [ORG_W-1:0] y_origin_reg;
    logic             wr_en;
    logic             reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_origin_reg <= '0;
            y_origin_reg <= '0;
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_X_ORIGIN)
                x_origin_reg <= pwdata[ORG_W-1:0];
            else
                y_origin_reg <= pwdata[ORG_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_sel == REG_X_ORIGIN)
            prdata = APB_DW'(x_origin_reg);
        else
            prdata = APB_DW'(y_origin_reg);
    end

    assign cfg.x_origin = x_origin_reg;
    assign cfg.y_origin = y_origin_reg;

endmodule

/* sv/bmpd_parser.sv */
`timescale 1ns / 1ps
// bmpd_parser: header parse, pixel assembly and coordinate generation,
// one file byte per step. Depends on bmpd_pkg.
module bmpd_parser
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  bmpd_pkg::cfg_t    cfg,
    input  bmpd_pkg::step_t   req,
    output logic              produce,
    output bmpd_pkg::result_t result
);
    import bmpd_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 2);
    localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(MAX_DIM + 1);
    localparam logic [31:0] DIM_MAX32 = 32'(MAX_DIM);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PIXELS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [5:0] OFF_WIDTH  = 6'd21;
    localparam logic [5:0] OFF_HEIGHT = 6'd25;
    localparam logic [5:0] OFF_DEPTH  = 6'd29;
    localparam logic [5:0] OFF_LAST   = 6'd53;
    localparam logic [15:0] DEPTH_24  = 16'd24;
    localparam logic [15:0] DEPTH_32  = 16'd32;

    logic [5:0]       byte_offset_reg, byte_offset_next;
    logic [31:0]      header_shift_reg, header_shift_next;
    logic [DIM_W-1:0] image_width_reg, image_width_next;
    logic             width_negative_reg, width_negative_next;
    logic [DIM_W-1:0] image_height_reg, image_height_next;
    logic             height_negative_reg, height_negative_next;
    logic             four_byte_pixels_reg, four_byte_pixels_next;
    logic [1:0]       pixel_byte_index_reg, pixel_byte_index_next;
    logic [23:0]      pixel_bytes_reg, pixel_bytes_next;
    logic [DIM_W-1:0] column_reg, column_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [1:0]       pad_remaining_reg, pad_remaining_next;
    logic [1:0]       phase_reg, phase_next;

    // current state after an optional restart
    logic [1:0]       c_phase;
    logic [5:0]       c_offset;
    logic [31:0]      c_shift;
    logic [31:0]      shift_in;
    logic [31:0]      mag;
    logic [DIM_W-1:0] mag_sat;
    logic [15:0]      depth;
    logic [1:0]       need;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic [1:0]       w3;
    logic [SCR_W-1:0] x_org;
    logic [SCR_W-1:0] y_org;
    logic [SCR_W-1:0] w_ext;
    logic [SCR_W-1:0] h_ext;
    logic [SCR_W-1:0] col_ext;
    logic [SCR_W-1:0] row_ext;

    assign c_phase  = req.first_byte ? PH_HEADER : phase_reg;
    assign c_offset = req.first_byte ? 6'd0 : byte_offset_reg;
    assign c_shift  = req.first_byte ? 32'd0 : header_shift_reg;
    assign shift_in = {req.file_byte, c_shift[31:8]};
    assign depth    = shift_in[31:16];

    always_comb
    begin
        mag = shift_in[31] ? (32'd0 - shift_in) : shift_in;
        if (mag > DIM_MAX32)
            mag_sat = DIM_SAT;
        else
            mag_sat = mag[DIM_W-1:0];
    end

    assign need    = four_byte_pixels_reg ? 2'd3 : 2'd2;
    assign col_inc = column_reg + DIM_W'(1);
    assign row_inc = row_reg + DIM_W'(1);
    assign w3      = image_width_reg[1:0] + {image_width_reg[0], 1'b0};
    assign x_org   = SCR_W'(cfg.x_origin);
    assign y_org   = SCR_W'(cfg.y_origin);
    assign w_ext   = SCR_W'(image_width_reg);
    assign h_ext   = SCR_W'(image_height_reg);
    assign col_ext = SCR_W'(column_reg);
    assign row_ext = SCR_W'(row_reg);

    always_comb
    begin
        byte_offset_next      = c_offset;
        header_shift_next     = c_shift;
        image_width_next      = req.first_byte ? '0 : image_width_reg;
        width_negative_next   = req.first_byte ? 1'b0 : width_negative_reg;
        image_height_next     = req.first_byte ? '0 : image_height_reg;
        height_negative_next  = req.first_byte ? 1'b0 : height_negative_reg;
        four_byte_pixels_next = req.first_byte ? 1'b0 : four_byte_pixels_reg;
        pixel_byte_index_next = req.first_byte ? 2'd0 : pixel_byte_index_reg;
        pixel_bytes_next      = req.first_byte ? 24'd0 : pixel_bytes_reg;
        column_next           = req.first_byte ? '0 : column_reg;
        row_next              = req.first_byte ? '0 : row_reg;
        pad_remaining_next    = req.first_byte ? 2'd0 : pad_remaining_reg;
        phase_next            = c_phase;
        produce               = 1'b0;
        result                = '0;

        case (c_phase)
            PH_HEADER:
            begin
                header_shift_next = shift_in;
                if (c_offset == OFF_WIDTH)
                begin
                    image_width_next    = mag_sat;
                    width_negative_next = shift_in[31];
                end
                else if (c_offset == OFF_HEIGHT)
                begin
                    image_height_next    = mag_sat;
                    height_negative_next = shift_in[31];
                end
                if (c_offset == OFF_DEPTH && depth != DEPTH_24 && depth != DEPTH_32)
                begin
                    phase_next  = PH_DONE;
                    produce     = 1'b1;
                    result.kind = KIND_BAD_DEPTH;
                end
                else if (c_offset == OFF_DEPTH &&
                         (image_width_reg > DIM_W'(MAX_DIM) ||
                          image_height_reg > DIM_W'(MAX_DIM)))
                begin
                    four_byte_pixels_next = (depth == DEPTH_32);
                    phase_next  = PH_DONE;
                    produce     = 1'b1;
                    result.kind = KIND_TOO_LARGE;
                end
                else
                begin
                    if (c_offset == OFF_DEPTH)
                        four_byte_pixels_next = (depth == DEPTH_32);
                    if (c_offset >= OFF_LAST)
                    begin
                        phase_next = (image_width_reg == '0 || image_height_reg == '0) ?
                                     PH_DONE : PH_PIXELS;
                        column_next           = '0;
                        row_next              = '0;
                        pixel_byte_index_next = 2'd0;
                        pixel_bytes_next      = 24'd0;
                        pad_remaining_next    = 2'd0;
                    end
                    else
                    begin
                        byte_offset_next = c_offset + 6'd1;
                    end
                end
            end
            PH_PIXELS:
            begin
                if (pad_remaining_reg != 2'd0)
                begin
                    pad_remaining_next = pad_remaining_reg - 2'd1;
                end
                else if (pixel_byte_index_reg < need)
                begin
                    case (pixel_byte_index_reg)
                        2'd0:    pixel_bytes_next[7:0]   = req.file_byte;
                        2'd1:    pixel_bytes_next[15:8]  = req.file_byte;
                        default: pixel_bytes_next[23:16] = req.file_byte;
                    endcase
                    pixel_byte_index_next = pixel_byte_index_reg + 2'd1;
                end
                else
                begin
                    produce = 1'b1;
                    result.kind = KIND_PIXEL;
                    if (four_byte_pixels_reg)
                        result.argb = {req.file_byte, pixel_bytes_reg};
                    else
                        result.argb = {8'd0, req.file_byte, pixel_bytes_reg[15:0]};
                    result.screen_x = width_negative_reg ?
                                      (x_org + w_ext - SCR_W'(1) - col_ext) :
                                      (x_org + col_ext);
                    result.screen_y = height_negative_reg ?
                                      (y_org + row_ext) :
                                      (y_org + h_ext - SCR_W'(1) - row_ext);
                    result.last_pixel = (col_inc == image_width_reg) &&
                                        (row_inc == image_height_reg);
                    pixel_byte_index_next = 2'd0;
                    pixel_bytes_next      = 24'd0;
                    if (col_inc >= image_width_reg)
                    begin
                        column_next = '0;
                        row_next    = row_inc;
                        if (row_inc >= image_height_reg)
                            phase_next = PH_DONE;
                        else if (!four_byte_pixels_reg)
                            pad_remaining_next = 2'd0 - w3;
                    end
                    else
                    begin
                        column_next = col_inc;
                    end
                end
            end
            default:
            begin
                phase_next = c_phase;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg      <= '0;
            header_shift_reg     <= '0;
            image_width_reg      <= '0;
            width_negative_reg   <= 1'b0;
            image_height_reg     <= '0;
            height_negative_reg  <= 1'b0;
            four_byte_pixels_reg <= 1'b0;
            pixel_byte_index_reg <= '0;
            pixel_bytes_reg      <= '0;
            column_reg           <= '0;
            row_reg              <= '0;
            pad_remaining_reg    <= '0;
            phase_reg            <= PH_HEADER;
        end
        else if (req.step)
        begin
            byte_offset_reg      <= byte_offset_next;
            header_shift_reg     <= header_shift_next;
            image_width_reg      <= image_width_next;
            width_negative_reg   <= width_negative_next;
            image_height_reg     <= image_height_next;
            height_negative_reg  <= height_negative_next;
            four_byte_pixels_reg <= four_byte_pixels_next;
            pixel_byte_index_reg <= pixel_byte_index_next;
            pixel_bytes_reg      <= pixel_bytes_next;
            column_reg           <= column_next;
            row_reg              <= row_next;
            pad_remaining_reg    <= pad_remaining_next;
            phase_reg            <= phase_next;
        end
    end

endmodule

/* sv/bmp_pixel_stream_decoder.sv */
`timescale 1ns / 1ps
// bmp_pixel_stream_decoder: top level with input and result registers.
// Depends on bmpd_pkg, bmpd_cfg and bmpd_parser.
//
// Decodes a 24- or 32-bit BMP file fed one byte per request, first_byte
// marking offset zero. Each pixel request yields an ARGB word and its screen
// coordinate (origin from the APB registers, flipped by the header signs);
// a bad depth or an image larger than MAX_DIM yields one error result on
// header byte 29. A byte passes through the input register and then through
// the parser into the result register. One byte is accepted per cycle,
// sustained, while the output side keeps up; the input register can take a
// new byte while a result waits downstream if the byte it holds yields no result.
module bmp_pixel_stream_decoder
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bmpd_pkg::APB_AW-1:0]   paddr,
    input  logic [bmpd_pkg::APB_DW-1:0]   pwdata,
    output logic [bmpd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bmpd_pkg::BYTE_W-1:0]   file_byte,
    input  logic                          first_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bmpd_pkg::KIND_W-1:0]   kind,
    output logic [bmpd_pkg::SCR_W-1:0]    screen_x,
    output logic [bmpd_pkg::SCR_W-1:0]    screen_y,
    output logic [bmpd_pkg::ARGB_W-1:0]   argb,
    output logic                          last_pixel
);
    import bmpd_pkg::*;

    cfg_t              cfg;
    step_t             req;
    result_t           result;
    logic              produce;
    logic              advance;
    logic              ib_valid_reg, ib_valid_next;
    logic [BYTE_W-1:0] ib_byte_reg;
    logic              ib_first_reg;
    logic              ob_valid_reg, ob_valid_next;
    result_t           ob_reg;

    bmpd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = ib_valid_reg && (!produce || !ob_valid_reg || out_ready);
    assign in_ready = !ib_valid_reg || advance;

    assign req.step       = advance;
    assign req.file_byte  = ib_byte_reg;
    assign req.first_byte = ib_first_reg;

    bmpd_parser #(.MAX_DIM(MAX_DIM)) u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .produce (produce),
        .result  (result)
    );

    always_comb
    begin
        ib_valid_next = ib_valid_reg;
        if (in_valid && in_ready)
            ib_valid_next = 1'b1;
        else if (advance)
            ib_valid_next = 1'b0;

        ob_valid_next = ob_valid_reg;
        if (advance && produce)
            ob_valid_next = 1'b1;
        else if (out_ready)
            ob_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg <= 1'b0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            ib_valid_reg <= ib_valid_next;
            ob_valid_reg <= ob_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ib_byte_reg  <= file_byte;
            ib_first_reg <= first_byte;
        end
        if (advance && produce)
            ob_reg <= result;
    end

    assign out_valid  = ob_valid_reg;
    assign kind       = ob_reg.kind;
    assign screen_x   = ob_reg.screen_x;
    assign screen_y   = ob_reg.screen_y;
    assign argb       = ob_reg.argb;
    assign last_pixel = ob_reg.last_pixel;

endmodule
